### sv/pbmr_pkg.sv
// ----------------------------------------------------------------------------
// pbmr_pkg
// Types and constants shared by the max-binning histogram block.
// ----------------------------------------------------------------------------
package pbmr_pkg;

  localparam int unsigned MaxBinsDefault = 4096;
  localparam int unsigned PosW = 40;
  localparam int unsigned ValW = 32;
  localparam int unsigned IdxW = 12;
  localparam int unsigned NbW  = 13;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_X_START   = 2'd0,
    CFG_BIN_WIDTH = 2'd1,
    CFG_NUM_BINS  = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_WR,
    ST_OUT,
    ST_CLR
  } state_e;

  typedef struct packed {
    logic [1:0]      func;
    logic [PosW-1:0] x_pos;
    logic [ValW-1:0] intensity;
    logic [IdxW-1:0] bin_index;
  } in_item_t;

  typedef struct packed {
    logic [ValW-1:0] bin_value;
    logic            bin_filled;
    logic            bad_index;
  } out_item_t;

  // Divider handshake between the top level and the divider.
  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

### sv/profile_bin_max_reduce.sv
// Operation: an add holds the block through a 42-step serial divide and, when
// the sample lands in a bin, a read and write of the bin memory. A read holds
// it until its result is registered, waiting while the previous result is held;
// a clear sweeps the valid memory of all MAX_BINS bins.
// Reset: registers take their reset values and a clearing pass sweeps the
// valid memory before the first item is accepted.
// ----------------------------------------------------------------------------
// profile_bin_max_reduce
// Max-binning histogram with per-bin maximum and valid memories.
// ----------------------------------------------------------------------------
module profile_bin_max_reduce
  import pbmr_pkg::*;
#(
  parameter int unsigned MAX_BINS = MaxBinsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [PosW-1:0]    cfg_data_i
);

  localparam int unsigned AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned QW = 18;

  logic [PosW-1:0] x_start_q, bin_width_q;
  logic [NbW-1:0]  num_bins_q;
  logic [16:0]     nb_use;

  state_e state_q, state_d;
  in_item_t item_q;
  logic [AW:0] clr_q, clr_d;
  logic [AW-1:0] addr_q, addr_d;
  logic in_rng_q, in_rng_d;
  out_item_t out_q, out_d;
  logic out_v_q, out_v_d;

  logic [ValW-1:0] max_mem [MAX_BINS];
  logic            vld_mem [MAX_BINS];
  logic [ValW-1:0] max_rd_q;
  logic            vld_rd_q;
  logic            mem_we, vld_we, vld_wv;
  logic [AW-1:0]   vld_wa;

  // Divider operands.
  logic [PosW-1:0] w_eff;
  logic [41:0]     num, den;
  logic            above, near_below;
  logic            add_hit;
  logic            out_free;
  logic            div_start;
  div_ctl_t        div_ctl;
  logic [QW-1:0]   quo;

  assign nb_use = (17'(num_bins_q) > 17'(MAX_BINS)) ? 17'(MAX_BINS) : 17'(num_bins_q);
  assign w_eff = (bin_width_q == '0) ? PosW'(1) : bin_width_q;
  assign above = item_q.x_pos >= x_start_q;
  assign near_below = ({1'b0, x_start_q - item_q.x_pos, 1'b0}) <= {2'b0, w_eff};
  // The divider takes its operands at the accepting edge, from the incoming item.
  assign num = {1'b0, in_data_i.x_pos - x_start_q, 1'b0} + {2'b0, w_eff};
  assign den = {1'b0, w_eff, 1'b0};
  assign add_hit = above ? (quo < QW'(nb_use)) : (near_below && (nb_use != '0));
  assign out_free = !out_v_q || out_ready_i;

  pbmr_div #(.QW(QW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num), .den_i(den),
    .ctl_o(div_ctl), .quo_o(quo)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLR:  if (clr_q == (AW+1)'(MAX_BINS - 1)) state_d = ST_IDLE;
      ST_IDLE: if (in_valid_i && in_ready_o) begin
        case (in_data_i.func)
          FUNC_ADD:   state_d = ST_DIV;
          FUNC_READ:  state_d = ST_RD;
          FUNC_CLEAR: state_d = ST_CLR;
          default:    state_d = ST_IDLE;
        endcase
      end
      ST_DIV:  if (div_ctl.done) state_d = add_hit ? ST_RD : ST_IDLE;
      ST_RD:   state_d = (item_q.func == FUNC_ADD) ? ST_WR : ST_OUT;
      ST_WR:   state_d = ST_IDLE;
      // A read waits here while the previous result is still held.
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    clr_d = '0; addr_d = addr_q; in_rng_d = in_rng_q;
    out_d = out_q; out_v_d = out_v_q && !out_ready_i;
    div_start = 1'b0; mem_we = 1'b0; vld_we = 1'b0; vld_wv = 1'b0;
    vld_wa = addr_q;
    case (state_q)
      ST_CLR: begin
        clr_d = clr_q + 1'b1; vld_we = 1'b1; vld_wa = clr_q[AW-1:0];
      end
      ST_IDLE: if (in_valid_i && in_ready_o) begin
        addr_d = AW'(in_data_i.bin_index);
        in_rng_d = (17'(in_data_i.bin_index) < nb_use);
        div_start = (in_data_i.func == FUNC_ADD);
      end
      ST_DIV: begin
        if (div_ctl.done) begin
          in_rng_d = add_hit;
          addr_d = above ? AW'(quo) : '0;
        end
      end
      ST_WR: begin
        mem_we = !vld_rd_q || (max_rd_q < item_q.intensity);
        vld_we = 1'b1; vld_wv = 1'b1;
      end
      ST_OUT: if (out_free) begin
        out_v_d = 1'b1;
        if (!in_rng_q) out_d = '{bin_value: '0, bin_filled: 1'b0, bad_index: 1'b1};
        else if (vld_rd_q) out_d = '{bin_value: max_rd_q, bin_filled: 1'b1, bad_index: 1'b0};
        else out_d = '{bin_value: '0, bin_filled: 1'b0, bad_index: 1'b0};
      end
      default: ;
    endcase
  end

  // Bin memories, registered reads.
  always_ff @(posedge clk_i) begin
    if (mem_we) max_mem[addr_q] <= item_q.intensity;
    max_rd_q <= max_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (vld_we) vld_mem[vld_wa] <= vld_wv;
    vld_rd_q <= vld_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i && in_ready_o) item_q <= in_data_i;
    out_q <= out_d;
    addr_q <= addr_d;
    in_rng_q <= in_rng_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR; clr_q <= '0; out_v_q <= 1'b0;
      x_start_q <= '0; bin_width_q <= PosW'(65536); num_bins_q <= NbW'(4096);
    end else begin
      state_q <= state_d; clr_q <= clr_d; out_v_q <= out_v_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_X_START:   x_start_q   <= cfg_data_i;
          CFG_BIN_WIDTH: bin_width_q <= cfg_data_i;
          CFG_NUM_BINS:  num_bins_q  <= cfg_data_i[NbW-1:0];
          default: ;
        endcase
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_ready_i |=> out_v_q) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ready_o) else $error("accept while busy");
  a_bad_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.bad_index |-> !out_q.bin_filled && out_q.bin_value == '0)
    else $error("bad read carries data");

endmodule

### sv/pbmr_div.sv
// ----------------------------------------------------------------------------
// pbmr_div
// Restoring divider, one quotient bit per cycle, saturating quotient.
// ----------------------------------------------------------------------------
module pbmr_div
  import pbmr_pkg::*;
#(
  parameter int unsigned QW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [41:0]   num_i,
  input  logic [41:0]   den_i,
  output div_ctl_t      ctl_o,
  output logic [QW-1:0] quo_o
);

  localparam int unsigned NW = 42;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] rem_q, rem_d;
  logic [NW-1:0] num_q, num_d;
  logic [NW-1:0] den_q, den_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [NW:0]   trial;
  logic [NW:0]   shifted;

  always_comb begin
    rem_d = rem_q; num_d = num_q; den_d = den_q; quo_d = quo_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    shifted = {rem_q, num_q[NW-1]};
    trial = shifted - {1'b0, den_q};
    if (start_i) begin
      rem_d = '0; num_d = num_i; den_d = den_i; quo_d = '0;
      cnt_d = CW'(NW); busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NW-2:0], 1'b0};
      if (!trial[NW]) begin
        rem_d = trial[NW-1:0];
        // Quotient saturates; any value past QW bits is out of range anyway.
        quo_d = (quo_q[QW-1]) ? '1 : {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_d = shifted[NW-1:0];
        quo_d = (quo_q[QW-1]) ? '1 : {quo_q[QW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; num_q <= num_d; den_q <= den_d; quo_q <= quo_d;
  end

  assign ctl_o.start = start_i;
  assign ctl_o.done  = done_q;
  assign quo_o = quo_q;

endmodule

### tb/pbmr_checker.sv
// ----------------------------------------------------------------------------
// pbmr_checker
// Watches the item, result and register channels of the max-binning
// histogram, keeps its own copy of the bin memories and compares each read
// result with the value predicted for it.
// ----------------------------------------------------------------------------
module pbmr_checker
  import pbmr_pkg::*;
#(
  parameter int unsigned MAX_BINS = MaxBinsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  in_item_t           in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  out_item_t          out_data_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [PosW-1:0]    cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_reads_o
);

  logic [PosW-1:0] x_start_q;
  logic [PosW-1:0] bin_width_q;
  logic [NbW-1:0]  num_bins_q;
  logic [ValW-1:0] peak_mem [MAX_BINS];
  bit              filled_mem [MAX_BINS];
  out_item_t       read_results_q[$];
  int              fails;

  assign fail_count_o    = fails;
  assign pending_reads_o = read_results_q.size();

  // Applies one accepted item to the predicted bin state.
  function automatic void bin_update(in_item_t it);
    logic [63:0] x, xs, w, b, nb;
    bit          hit;
    out_item_t   r;
    x  = 64'(it.x_pos);
    xs = 64'(x_start_q);
    w  = (bin_width_q == '0) ? 64'd1 : 64'(bin_width_q);
    nb = (num_bins_q > MAX_BINS) ? 64'(MAX_BINS) : 64'(num_bins_q);
    b   = '0;
    hit = 1'b0;
    case (func_e'(it.func))
      FUNC_ADD: begin
        // Round to the nearest bin centre; a half step below x_start still
        // lands in the first bin.
        if (x >= xs) begin
          b   = (64'd2 * (x - xs) + w) / (64'd2 * w);
          hit = 1'b1;
        end else if (64'd2 * (xs - x) <= w) begin
          hit = 1'b1;
        end
        if (hit && b < nb) begin
          if (!filled_mem[b] || peak_mem[b] < it.intensity) peak_mem[b] = it.intensity;
          filled_mem[b] = 1'b1;
        end
      end
      FUNC_READ: begin
        r = '0;
        if (64'(it.bin_index) >= nb) begin
          r.bad_index = 1'b1;
        end else if (filled_mem[it.bin_index]) begin
          r.bin_value  = peak_mem[it.bin_index];
          r.bin_filled = 1'b1;
        end
        read_results_q.push_back(r);
      end
      FUNC_CLEAR: begin
        foreach (filled_mem[i]) filled_mem[i] = 1'b0;
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    if (!rst_ni) begin
      x_start_q   <= '0;
      bin_width_q <= PosW'(65536);
      num_bins_q  <= NbW'(MAX_BINS);
      foreach (filled_mem[i]) filled_mem[i] = 1'b0;
      read_results_q.delete();
      fails = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (read_results_q.size() == 0) begin
          $error("result with no read waiting: %p", out_data_i);
          fails++;
        end else begin
          e = read_results_q.pop_front();
          if (e.bin_value !== out_data_i.bin_value) begin
            $error("bin_value expected %0d actual %0d", e.bin_value, out_data_i.bin_value);
            fails++;
          end
          if (e.bin_filled !== out_data_i.bin_filled) begin
            $error("bin_filled expected %0d actual %0d", e.bin_filled, out_data_i.bin_filled);
            fails++;
          end
          if (e.bad_index !== out_data_i.bad_index) begin
            $error("bad_index expected %0d actual %0d", e.bad_index, out_data_i.bad_index);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) bin_update(in_data_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_X_START:   x_start_q   <= cfg_data_i;
          CFG_BIN_WIDTH: bin_width_q <= cfg_data_i;
          CFG_NUM_BINS:  num_bins_q  <= cfg_data_i[NbW-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### tb/profile_bin_max_reduce_tb.sv
// ----------------------------------------------------------------------------
// profile_bin_max_reduce_tb
// Drives samples, reads and clears into the histogram under several bin
// layouts, with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module profile_bin_max_reduce_tb;
  import pbmr_pkg::*;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DrainCycles = 4300;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [PosW-1:0]    cfg_data;
  int                 fail_count;
  int                 pending_reads;
  bit                 calm;
  bit                 hold_req;
  bit                 hold_done;
  int                 quiet_cnt;

  // Our own view of the layout, used only to aim samples and reads at real bins.
  logic [63:0] cur_start, cur_width, cur_bins;

  profile_bin_max_reduce dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  pbmr_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_reads_o(pending_reads)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Receiver: random idling, a calm window, and one long hold-off once asked.
  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_done = 1'b1;
        out_ready <= 1'b1;
      end else if (calm) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 99) >= 10);
    end
  end

  initial begin
    quiet_cnt = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cnt = 0;
      else quiet_cnt++;
      if (quiet_cnt >= StallLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_item(in_item_t it);
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[PosW-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_X_START) cur_start = val;
    if (idx == CFG_BIN_WIDTH) cur_width = (val == 0) ? 64'd1 : val;
    if (idx == CFG_NUM_BINS) cur_bins = (val[NbW-1:0] > 4096) ? 64'd4096 : 64'(val[NbW-1:0]);
  endtask

  // Lets every read come back and any clear or add finish before a new layout.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_reads != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_layout(logic [63:0] s, logic [63:0] w, logic [63:0] n);
    settle();
    write_reg(CFG_X_START, s);
    write_reg(CFG_BIN_WIDTH, w);
    write_reg(CFG_NUM_BINS, n);
  endtask

  function automatic in_item_t item_of(func_e f, logic [63:0] x, logic [31:0] y,
                                       logic [11:0] idx);
    in_item_t it;
    it.func      = f;
    it.x_pos     = x[PosW-1:0];
    it.intensity = y;
    it.bin_index = idx;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t    it;
    int          pick;
    logic [63:0] k, off, x;
    logic [31:0] y;
    pick = $urandom_range(0, 99);
    y = $urandom();
    if ($urandom_range(0, 9) == 0) y = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
    it = item_of(FUNC_READ, {$urandom(), $urandom()}, $urandom(), 12'($urandom()));
    if (pick < 55) begin
      // Aim at a bin centre with an offset spanning a bit more than one bin.
      k   = $urandom_range(0, int'(cur_bins));
      off = {$urandom(), $urandom()} % (cur_width + 2);
      x   = cur_start + k * cur_width + off - (cur_width + 1) / 2;
      it  = item_of(FUNC_ADD, x, y, 12'($urandom()));
    end else if (pick < 63) begin
      it.func = FUNC_ADD;
      it.intensity = y;
    end else if (pick < 95) begin
      if ($urandom_range(0, 6) != 0 && cur_bins != 0)
        it.bin_index = 12'($urandom_range(0, int'(cur_bins) - 1));
    end else if (pick < 97) begin
      it.func = FUNC_CLEAR;
    end else begin
      it.func = FUNC_NONE;
    end
    return it;
  endfunction

  initial begin
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_X_START;
    cfg_data  = '0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    cur_start = 0;
    cur_width = 65536;
    cur_bins  = 4096;
    @(posedge rst_n);
    @(posedge clk);

    // Directed: default layout, one bin per 65536 units of position.
    send_item(item_of(FUNC_READ, 0, 0, 12'd0));
    send_item(item_of(FUNC_ADD, 0, 32'hFFFF_FFFF, 12'd0));
    send_item(item_of(FUNC_ADD, 64'd32767, 32'd5, 12'd0));
    send_item(item_of(FUNC_READ, 0, 0, 12'd0));
    send_item(item_of(FUNC_ADD, 64'd32768, 32'd7, 12'd0));
    send_item(item_of(FUNC_ADD, 64'd98304, 32'd3, 12'd0));
    send_item(item_of(FUNC_ADD, 64'd98303, 32'd9, 12'd0));
    send_item(item_of(FUNC_READ, 0, 0, 12'd1));
    send_item(item_of(FUNC_READ, 0, 0, 12'd2));
    send_item(item_of(FUNC_ADD, 64'd4095 << 16, 32'd0, 12'd0));
    send_item(item_of(FUNC_ADD, 64'hFF_FFFF_FFFF, 32'd11, 12'hFFF));
    send_item(item_of(FUNC_READ, 0, 0, 12'hFFF));
    send_item(item_of(FUNC_NONE, 64'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF));
    send_item(item_of(FUNC_CLEAR, 0, 0, 12'd0));
    send_item(item_of(FUNC_READ, 0, 0, 12'd0));
    send_item(item_of(FUNC_READ, 0, 0, 12'd1));

    // Zero width acts as one, a single bin, and a start above the sample.
    set_layout(64'd100, 64'd0, 64'd1);
    send_item(item_of(FUNC_ADD, 64'd99, 32'd4, 12'd0));
    send_item(item_of(FUNC_ADD, 64'd98, 32'd8, 12'd0));
    send_item(item_of(FUNC_ADD, 64'd101, 32'd8, 12'd0));
    send_item(item_of(FUNC_READ, 0, 0, 12'd0));
    send_item(item_of(FUNC_READ, 0, 0, 12'd1));
    settle();
    write_reg(CFG_UNUSED, 64'hFF_FFFF_FFFF);

    // Zero bins: every sample dropped, every read flagged.
    set_layout(64'd0, 64'd65536, 64'd0);
    send_item(item_of(FUNC_ADD, 64'd0, 32'd1, 12'd0));
    send_item(item_of(FUNC_READ, 0, 0, 12'd0));

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_layout(64'hFF_FFFF_FFFF, 64'hFF_FFFF_FFFF, 64'd8191);
        1: set_layout(64'd1000 << 16, 64'd3 << 15, 64'd16);
        2: set_layout(64'd0, 64'd1, 64'd4096);
        3: set_layout(64'($urandom_range(0, 1 << 30)), 64'($urandom_range(1, 1 << 20)),
                      64'($urandom_range(1, 64)));
        4: set_layout(64'($urandom()), 64'($urandom_range(1, 1 << 24)), 64'd5000);
        default: set_layout(64'($urandom_range(0, 1 << 20)), 64'($urandom_range(1, 4096)),
                            64'($urandom_range(2, 32)));
      endcase
      calm = (phase == 3);
      // The receiver holds off for a long stretch while items keep coming.
      if (phase == 2) hold_req = 1'b1;
      for (int n = 0; n < 140; n++) send_item(random_item());
      calm = 1'b0;
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending_reads != 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending_reads == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
